>>> design/sspr_pkg.sv
// Shared constants, types and helpers of the servo status packet receiver.
`timescale 1ns / 1ps
package sspr_pkg;

  // Largest parameter store the index field can address.
  localparam int unsigned StoreCap      = 32;
  localparam int unsigned MaxParamsDef  = 32;

  localparam logic       OpByte         = 1'b0;
  localparam logic       OpTimeout      = 1'b1;

  localparam logic       KindStatus     = 1'b0;
  localparam logic       KindParam      = 1'b1;

  localparam logic [3:0] StOk           = 4'd0;
  localparam logic [3:0] StTimeout      = 4'd1;
  localparam logic [3:0] StChecksum     = 4'd2;
  localparam logic [3:0] StStart        = 4'd3;
  localparam logic [3:0] StId           = 4'd4;
  localparam logic [3:0] StInstruction  = 4'd5;
  localparam logic [3:0] StOverload     = 4'd6;
  localparam logic [3:0] StServoSum     = 4'd7;
  localparam logic [3:0] StRange        = 4'd8;
  localparam logic [3:0] StOverheat     = 4'd9;
  localparam logic [3:0] StAngleLimit   = 4'd10;
  localparam logic [3:0] StVoltage      = 4'd11;
  localparam logic [3:0] StLength       = 4'd12;

  localparam logic [7:0] StartByte      = 8'hff;
  localparam logic [5:0] PosId          = 6'd2;
  localparam logic [5:0] PosLength      = 6'd3;
  localparam logic [5:0] PosError       = 6'd4;
  localparam logic [5:0] ParamFirst     = 6'd5;
  localparam logic [5:0] LenOverhead    = 6'd4;
  localparam logic [7:0] MinLen         = 8'd2;

  typedef struct packed {
    logic       valid;
    logic [3:0] status;
    logic [5:0] nparams;
  } evt_t;

  // Highest set error bit wins; bit 7 maps to no code.
  function automatic logic [3:0] servo_err_code(input logic [7:0] e);
    logic [3:0] code;
    code = StOk;
    if (e[0]) code = StVoltage;
    if (e[1]) code = StAngleLimit;
    if (e[2]) code = StOverheat;
    if (e[3]) code = StRange;
    if (e[4]) code = StServoSum;
    if (e[5]) code = StOverload;
    if (e[6]) code = StInstruction;
    return code;
  endfunction

endpackage

>>> design/sspr_ifs.sv
// Valid/ready channel interfaces for received words and result words.
`timescale 1ns / 1ps
interface sspr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface sspr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] status;
  logic [7:0] param_byte;
  logic [4:0] param_index;
  logic       last;

  modport source (output valid, output kind, output status, output param_byte,
                  output param_index, output last, input ready);
  modport sink   (input valid, input kind, input status, input param_byte,
                  input param_index, input last, output ready);
endinterface

>>> design/sspr_param_ram.sv
// Parameter store: one write port, one registered read port.
`timescale 1ns / 1ps
module sspr_param_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> design/sspr_frame_ctl.sv
// Packet parser: byte position, length and checksum tracking, final checks.
`timescale 1ns / 1ps
module sspr_frame_ctl #(
  parameter int unsigned CAP = 32,
  parameter int unsigned AW  = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic          op_i,
  input  logic [7:0]    byte_i,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_data_o,
  output sspr_pkg::evt_t evt_o
);
  import sspr_pkg::*;

  localparam logic [8:0] LenMax = 9'(CAP + 2);

  logic [5:0] cnt_q,   cnt_d;
  logic [5:0] total_q, total_d;
  logic [7:0] sum_q,   sum_d;
  logic       start_ok_q, start_ok_d;
  logic [7:0] id_q,    id_d;
  logic [7:0] err_q,   err_d;
  logic [7:0] exp_id_q;
  logic       restart;
  logic [5:0] np;
  logic [3:0] st;
  logic [5:0] pidx;

  assign np   = total_q - (LenOverhead + 6'(MinLen));
  assign pidx = cnt_q - ParamFirst;

  always_comb begin
    cnt_d      = cnt_q;
    total_d    = total_q;
    sum_d      = sum_q;
    start_ok_d = start_ok_q;
    id_d       = id_q;
    err_d      = err_q;
    restart    = 1'b0;
    evt_o      = '0;
    wr_en_o    = 1'b0;
    wr_addr_o  = pidx[AW-1:0];
    wr_data_o  = byte_i;
    st         = StOk;
    if (byte_i != ~sum_q) begin
      st = StChecksum;
    end else if (!start_ok_q) begin
      st = StStart;
    end else if (id_q != exp_id_q) begin
      st = StId;
    end else begin
      st = servo_err_code(err_q);
    end

    if (acc_i) begin
      if (op_i == OpTimeout) begin
        evt_o.valid  = 1'b1;
        evt_o.status = StTimeout;
        restart      = 1'b1;
      end else if (cnt_q < PosId) begin
        if (byte_i != StartByte) start_ok_d = 1'b0;
        cnt_d = cnt_q + 6'd1;
      end else if (cnt_q == PosId) begin
        id_d  = byte_i;
        sum_d = sum_q + byte_i;
        cnt_d = cnt_q + 6'd1;
      end else if (cnt_q == PosLength) begin
        if (byte_i < MinLen || {1'b0, byte_i} > LenMax) begin
          evt_o.valid  = 1'b1;
          evt_o.status = StLength;
          restart      = 1'b1;
        end else begin
          total_d = byte_i[5:0] + LenOverhead;
          sum_d   = sum_q + byte_i;
          cnt_d   = cnt_q + 6'd1;
        end
      end else if (cnt_q == PosError) begin
        err_d = byte_i;
        sum_d = sum_q + byte_i;
        cnt_d = cnt_q + 6'd1;
      end else if (cnt_q + 6'd1 < total_q) begin
        wr_en_o = 1'b1;
        sum_d   = sum_q + byte_i;
        cnt_d   = cnt_q + 6'd1;
      end else begin
        // checksum word closes the frame
        evt_o.valid   = 1'b1;
        evt_o.status  = st;
        evt_o.nparams = (st == StOk) ? np : 6'd0;
        restart       = 1'b1;
      end
    end

    if (restart) begin
      cnt_d      = '0;
      total_d    = '0;
      sum_d      = '0;
      start_ok_d = 1'b1;
      id_d       = '0;
      err_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      total_q    <= '0;
      sum_q      <= '0;
      start_ok_q <= 1'b1;
      id_q       <= '0;
      err_q      <= '0;
      exp_id_q   <= 8'd1;
    end else begin
      cnt_q      <= cnt_d;
      total_q    <= total_d;
      sum_q      <= sum_d;
      start_ok_q <= start_ok_d;
      id_q       <= id_d;
      err_q      <= err_d;
      if (cfg_we_i) begin
        exp_id_q <= cfg_wdata_i;
      end
    end
  end

endmodule

>>> design/sspr_emit.sv
// Result sequencer: status word, then parameter words streamed from the store.
`timescale 1ns / 1ps
module sspr_emit #(
  parameter int unsigned AW = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sspr_pkg::evt_t evt_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic           kind_o,
  output logic [3:0]     status_o,
  output logic [7:0]     param_byte_o,
  output logic [4:0]     param_index_o,
  output logic           last_o,
  output logic           busy_o,
  output logic           re_o,
  output logic [AW-1:0]  raddr_o,
  input  logic [7:0]     rdata_i
);
  import sspr_pkg::*;

  logic       ov_q, ov_d;
  logic       busy_q, busy_d;
  logic       dv_q, dv_d;
  logic [5:0] np_q, np_d;
  logic [5:0] rd_cnt_q, rd_cnt_d;
  logic [5:0] out_cnt_q, out_cnt_d;
  logic       kind_q, kind_d;
  logic [3:0] status_q, status_d;
  logic [7:0] pbyte_q, pbyte_d;
  logic [4:0] pidx_q, pidx_d;
  logic       last_q, last_d;
  logic       out_free;
  logic       issue;
  logic       load_p;

  assign out_free = !ov_q || out_ready_i;
  // read one entry ahead while the fetched word has a place to go
  assign issue    = busy_q && (rd_cnt_q != np_q) && (!dv_q || out_free);
  assign load_p   = busy_q && dv_q && out_free;
  assign re_o     = issue;
  assign raddr_o  = rd_cnt_q[AW-1:0];

  always_comb begin
    ov_d      = ov_q && !out_ready_i;
    busy_d    = busy_q;
    dv_d      = dv_q;
    np_d      = np_q;
    rd_cnt_d  = rd_cnt_q;
    out_cnt_d = out_cnt_q;
    kind_d    = kind_q;
    status_d  = status_q;
    pbyte_d   = pbyte_q;
    pidx_d    = pidx_q;
    last_d    = last_q;
    if (evt_i.valid) begin
      ov_d      = 1'b1;
      kind_d    = KindStatus;
      status_d  = evt_i.status;
      pbyte_d   = '0;
      pidx_d    = '0;
      last_d    = (evt_i.nparams == 6'd0);
      busy_d    = (evt_i.nparams != 6'd0);
      np_d      = evt_i.nparams;
      rd_cnt_d  = '0;
      out_cnt_d = '0;
      dv_d      = 1'b0;
    end else begin
      if (load_p) begin
        ov_d      = 1'b1;
        kind_d    = KindParam;
        status_d  = StOk;
        pbyte_d   = rdata_i;
        pidx_d    = out_cnt_q[4:0];
        last_d    = (out_cnt_q + 6'd1 == np_q);
        out_cnt_d = out_cnt_q + 6'd1;
        if (out_cnt_q + 6'd1 == np_q) busy_d = 1'b0;
      end
      if (issue) begin
        rd_cnt_d = rd_cnt_q + 6'd1;
        dv_d     = 1'b1;
      end else if (load_p) begin
        dv_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q      <= 1'b0;
      busy_q    <= 1'b0;
      dv_q      <= 1'b0;
      np_q      <= '0;
      rd_cnt_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      ov_q      <= ov_d;
      busy_q    <= busy_d;
      dv_q      <= dv_d;
      np_q      <= np_d;
      rd_cnt_q  <= rd_cnt_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    status_q <= status_d;
    pbyte_q  <= pbyte_d;
    pidx_q   <= pidx_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = ov_q;
  assign kind_o        = kind_q;
  assign status_o      = status_q;
  assign param_byte_o  = pbyte_q;
  assign param_index_o = pidx_q;
  assign last_o        = last_q;
  assign busy_o        = busy_q;

endmodule

>>> design/servo_status_packet_receiver_unit.sv
// Top level of the servo status packet receiver.
//
// in_i carries one word per handshake: a received UART byte (op 0) or a read
// timeout event (op 1). out_o delivers result words: one status word per
// finished packet, timeout or bad length, followed on a good packet by its
// parameter words in order; last marks the final word caused by an input.
// cfg_we_i/cfg_wdata_i write the expected servo ID (reset value 1).
//
// A result appears on out_o in the cycle after the word that causes it is
// accepted. A word that closes no packet produces nothing and the next word
// may follow in the next cycle. A good packet with N parameters adds N
// parameter words, read from the parameter store one entry ahead: the first
// follows the status word once its store read has returned, the rest at one
// per cycle while the receiver takes them. in_i.ready stays low until the
// last one is loaded. Otherwise in_i.ready is high whenever the output word
// is empty or being taken. A stalled receiver holds the output word and
// stalls in_i.
// Reset clears the frame state and the output valid flag; the parameter store
// is not cleared, since every entry read was written in the same frame.
`timescale 1ns / 1ps
module servo_status_packet_receiver_unit #(
  parameter int unsigned MAX_PARAMS = sspr_pkg::MaxParamsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sspr_in_if.sink           in_i,
  sspr_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);
  import sspr_pkg::*;

  localparam int unsigned Cap = (MAX_PARAMS < StoreCap) ? MAX_PARAMS : StoreCap;
  localparam int unsigned AW  = (Cap > 1) ? $clog2(Cap) : 1;

  logic          acc;
  logic          busy;
  logic          ov;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  evt_t          evt;

  assign in_i.ready  = !busy && (!ov || out_o.ready);
  assign acc         = in_i.valid && in_i.ready;
  assign out_o.valid = ov;

  sspr_frame_ctl #(.CAP(Cap), .AW(AW)) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .op_i       (in_i.op),
    .byte_i     (in_i.rx_byte),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .evt_o      (evt)
  );

  sspr_param_ram #(.DEPTH(Cap), .AW(AW)) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  sspr_emit #(.AW(AW)) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_i        (evt),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (ov),
    .kind_o       (out_o.kind),
    .status_o     (out_o.status),
    .param_byte_o (out_o.param_byte),
    .param_index_o(out_o.param_index),
    .last_o       (out_o.last),
    .busy_o       (busy),
    .re_o         (re),
    .raddr_o      (raddr),
    .rdata_i      (rdata)
  );

endmodule

>>> design/sspr_checker.sv
// Port-level checks for the servo status packet receiver, bound to the top.
`timescale 1ns / 1ps
module sspr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [3:0] out_status,
  input logic [7:0] out_pbyte,
  input logic [4:0] out_pidx,
  input logic       out_last
);
  import sspr_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_status)
      && $stable(out_pbyte) && $stable(out_pidx) && $stable(out_last))
    else $error("result word changed while stalled");

  a_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_op == OpTimeout |=>
      out_valid && out_kind == KindStatus && out_status == StTimeout && out_last)
    else $error("timeout did not produce a timeout status word");

  a_stream_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken while a parameter stream is pending");

  a_word_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_kind == KindParam && out_status == StOk)
      || (out_kind == KindStatus && out_status <= StLength
          && (out_last || out_status == StOk)))
    else $error("malformed result word");

endmodule

bind servo_status_packet_receiver_unit sspr_checker u_sspr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_op     (in_i.op),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_kind  (out_o.kind),
  .out_status(out_o.status),
  .out_pbyte (out_o.param_byte),
  .out_pidx  (out_o.param_index),
  .out_last  (out_o.last)
);
